FILE: design/riff_wave_pcm_parser_assert.svh
// Assertion macros for the RIFF/WAVE PCM parser.
`ifndef RIFF_WAVE_PCM_PARSER_ASSERT_SVH
`define RIFF_WAVE_PCM_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RWP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RWP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RWP_ASSERT(lbl, prop, msg)
`define RWP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/rwp_pkg.sv
// Shared types and constants of the RIFF/WAVE PCM parser.
`default_nettype none
package rwp_pkg;

	typedef enum logic [6:0] {
		PH_HEADER = 7'b0000001,
		PH_CHDR   = 7'b0000010,
		PH_FMT    = 7'b0000100,
		PH_SKIP   = 7'b0001000,
		PH_DATA   = 7'b0010000,
		PH_PAD    = 7'b0100000,
		PH_FAIL   = 7'b1000000
	} phase_t;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HEADER = 3'd1;
	localparam logic [2:0] ST_CUT_HEADER = 3'd2;
	localparam logic [2:0] ST_BAD_FMT    = 3'd3;
	localparam logic [2:0] ST_BAD_DATA   = 3'd4;
	localparam logic [2:0] ST_NO_PCM     = 3'd5;
	localparam logic [2:0] ST_NO_DATA    = 3'd6;
	localparam logic [2:0] ST_LAYOUT     = 3'd7;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [31:0] FMT_MIN  = 32'd16;

	typedef struct packed {
		phase_t      phase;
		logic        cut_header;
		logic [2:0]  error_code;
		logic        format_ok;
		logic        data_seen;
		logic [15:0] channels;
		logic [15:0] bits;
		logic [15:0] align;
		logic [31:0] rate;
		logic [30:0] data_length;
	} parse_info_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [30:0] frame_total;
		logic [1:0]  play_format;
	} verdict_t;

endpackage
`default_nettype wire

FILE: design/rwp_verdict.sv
// Final verdict logic: status priority, layout check, frame count and play format.
`default_nettype none
module rwp_verdict import rwp_pkg::*; (
	input  parse_info_t info,
	output verdict_t    verdict
);

	always_comb begin
		logic       two_ch;
		logic       wide;
		logic       ch_ok;
		logic       bits_ok;
		logic [2:0] bpf;
		logic       mod_ok;
		logic       layout_ok;
		two_ch  = info.channels == 16'd2;
		wide    = info.bits == 16'd16;
		ch_ok   = (info.channels == 16'd1) || two_ch;
		bits_ok = (info.bits == 16'd8) || wide;
		case ({two_ch, wide}) inside
			2'b00:        bpf = 3'd1;
			2'b01, 2'b10: bpf = 3'd2;
			default:      bpf = 3'd4;
		endcase
		mod_ok = (info.data_length[1:0] & (bpf[1:0] - 2'd1)) == 2'd0;
		layout_ok = ch_ok && bits_ok && (info.rate != 32'd0) && !info.rate[31] &&
			(info.align == {13'd0, bpf}) && mod_ok;

		if (info.phase == PH_FAIL) verdict.status = info.error_code;
		else if (info.phase == PH_HEADER) verdict.status = ST_BAD_HEADER;
		else if (info.phase == PH_CHDR && info.cut_header) verdict.status = ST_CUT_HEADER;
		else if (info.phase == PH_FMT) verdict.status = ST_BAD_FMT;
		else if (info.phase == PH_DATA) verdict.status = ST_BAD_DATA;
		else if (!info.format_ok) verdict.status = ST_NO_PCM;
		else if (!info.data_seen) verdict.status = ST_NO_DATA;
		else if (!layout_ok) verdict.status = ST_LAYOUT;
		else verdict.status = ST_OK;

		verdict.frame_total = 31'd0;
		verdict.play_format = 2'd0;
		if (verdict.status == ST_OK) begin
			verdict.play_format = {two_ch, wide};
			case (bpf)
				3'd1:    verdict.frame_total = info.data_length;
				3'd2:    verdict.frame_total = {1'b0, info.data_length[30:1]};
				default: verdict.frame_total = {2'b00, info.data_length[30:2]};
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/riff_wave_pcm_parser.sv
// Top level of the RIFF/WAVE PCM parser: input register, chunk walker and result register.
`default_nettype none
`include "riff_wave_pcm_parser_assert.svh"
// The parser takes one file byte or one end-of-stream marker per clock while
// the output is not held; only data bytes and the end marker produce a result
// transaction, so the rate is at most one transaction per clock. The chunk
// walker and verdict are combinational between the input register and the
// result register, with fmt fields gathered in staging registers. Bytes of the
// first data chunk come out as audio transactions, and the end marker yields
// one verdict transaction after which the parser is ready for a new file. A
// held result only stops the input once the input register is full as well.
module riff_wave_pcm_parser import rwp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  file_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [7:0]       audio_byte,
	output logic [2:0]       status,
	output logic [15:0]      channel_count,
	output logic [15:0]      sample_bits,
	output logic [31:0]      rate_hz,
	output logic [15:0]      frame_bytes,
	output logic [30:0]      payload_size,
	output logic [30:0]      frame_total,
	output logic [1:0]       play_format
);

	logic        in_valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        fire;

	phase_t      phase_q, phase_d;
	logic [3:0]  byte_count_q, byte_count_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic        pad_q, pad_d;
	logic        format_ok_q, format_ok_d;
	logic [15:0] channels_q, channels_d;
	logic [15:0] bits_q, bits_d;
	logic [15:0] align_q, align_d;
	logic [31:0] rate_q, rate_d;
	logic        data_seen_q, data_seen_d;
	logic [30:0] data_length_q, data_length_d;
	logic [2:0]  error_q, error_d;
	logic        emit;

	logic [15:0] stage_tag_q;
	logic [15:0] stage_ch_q;
	logic [31:0] stage_rate_q;
	logic [15:0] stage_align_q;
	logic [7:0]  stage_bits_lo_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  audio_byte_q;
	logic [2:0]  status_q;
	logic [15:0] channel_count_q;
	logic [15:0] sample_bits_q;
	logic [31:0] rate_hz_q;
	logic [15:0] frame_bytes_q;
	logic [30:0] payload_size_q;
	logic [30:0] frame_total_q;
	logic [1:0]  play_format_q;

	parse_info_t info;
	verdict_t    verdict;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = in_valid_s1 && advance;
	assign in_stall = in_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			byte_s1 <= file_byte;
		end
	end

	always_comb begin
		logic [31:0] size;
		size = {byte_s1, len_q[23:0]};
		phase_d       = phase_q;
		byte_count_d  = byte_count_q;
		tag_d         = tag_q;
		len_d         = len_q;
		pad_d         = pad_q;
		format_ok_d   = format_ok_q;
		channels_d    = channels_q;
		bits_d        = bits_q;
		align_d       = align_q;
		rate_d        = rate_q;
		data_seen_d   = data_seen_q;
		data_length_d = data_length_q;
		error_d       = error_q;
		emit          = 1'b0;
		if (fire) begin
			if (mode_s1) begin
				emit          = 1'b1;
				phase_d       = PH_HEADER;
				byte_count_d  = 4'd0;
				tag_d         = 32'd0;
				len_d         = 32'd0;
				pad_d         = 1'b0;
				format_ok_d   = 1'b0;
				channels_d    = 16'd0;
				bits_d        = 16'd0;
				align_d       = 16'd0;
				rate_d        = 32'd0;
				data_seen_d   = 1'b0;
				data_length_d = 31'd0;
				error_d       = ST_OK;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if ((byte_count_q[3:2] == 2'b00 &&
							byte_s1 != TAG_RIFF[{~byte_count_q[1:0], 3'b000} +: 8]) ||
							(byte_count_q[3] &&
							byte_s1 != TAG_WAVE[{~byte_count_q[1:0], 3'b000} +: 8])) begin
							phase_d = PH_FAIL;
							error_d = ST_BAD_HEADER;
						end else if (byte_count_q == 4'd11) begin
							phase_d      = PH_CHDR;
							byte_count_d = 4'd0;
						end else begin
							byte_count_d = byte_count_q + 4'd1;
						end
					end
					PH_CHDR: begin
						byte_count_d = byte_count_q + 4'd1;
						if (byte_count_q[3:2] == 2'b00) begin
							tag_d = {tag_q[23:0], byte_s1};
						end else if (byte_count_q == 4'd4) begin
							len_d = {24'd0, byte_s1};
						end else begin
							len_d[{byte_count_q[1:0], 3'b000} +: 8] = byte_s1;
						end
						if (byte_count_q == 4'd7) begin
							pad_d        = size[0];
							byte_count_d = 4'd0;
							if (tag_q == TAG_FMT) begin
								if (size < FMT_MIN) begin
									phase_d = PH_FAIL;
									error_d = ST_BAD_FMT;
								end else begin
									len_d   = size - FMT_MIN;
									phase_d = PH_FMT;
								end
							end else if (tag_q == TAG_DATA && !data_seen_q) begin
								if (size == 32'd0 || size[31]) begin
									phase_d = PH_FAIL;
									error_d = ST_BAD_DATA;
								end else begin
									data_seen_d   = 1'b1;
									data_length_d = size[30:0];
									len_d         = size;
									phase_d       = PH_DATA;
								end
							end else begin
								len_d   = size;
								phase_d = (size != 32'd0) ? PH_SKIP : PH_CHDR;
							end
						end
					end
					PH_FMT: begin
						byte_count_d = byte_count_q + 4'd1;
						if (byte_count_q == 4'd15) begin
							format_ok_d  = stage_tag_q == 16'd1;
							channels_d   = stage_ch_q;
							rate_d       = stage_rate_q;
							align_d      = stage_align_q;
							bits_d       = {byte_s1, stage_bits_lo_q};
							byte_count_d = 4'd0;
							if (len_q != 32'd0) phase_d = PH_SKIP;
							else if (pad_q) phase_d = PH_PAD;
							else phase_d = PH_CHDR;
						end
					end
					PH_SKIP, PH_DATA: begin
						emit  = phase_q == PH_DATA;
						len_d = (len_q == 32'd0) ? 32'd0 : len_q - 32'd1;
						if (len_q <= 32'd1) begin
							phase_d      = pad_q ? PH_PAD : PH_CHDR;
							byte_count_d = 4'd0;
						end
					end
					PH_PAD: begin
						phase_d      = PH_CHDR;
						byte_count_d = 4'd0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			byte_count_q  <= 4'd0;
			tag_q         <= 32'd0;
			len_q         <= 32'd0;
			pad_q         <= 1'b0;
			format_ok_q   <= 1'b0;
			channels_q    <= 16'd0;
			bits_q        <= 16'd0;
			align_q       <= 16'd0;
			rate_q        <= 32'd0;
			data_seen_q   <= 1'b0;
			data_length_q <= 31'd0;
			error_q       <= ST_OK;
		end else begin
			phase_q       <= phase_d;
			byte_count_q  <= byte_count_d;
			tag_q         <= tag_d;
			len_q         <= len_d;
			pad_q         <= pad_d;
			format_ok_q   <= format_ok_d;
			channels_q    <= channels_d;
			bits_q        <= bits_d;
			align_q       <= align_d;
			rate_q        <= rate_d;
			data_seen_q   <= data_seen_d;
			data_length_q <= data_length_d;
			error_q       <= error_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !mode_s1 && phase_q == PH_FMT) begin
			case (byte_count_q)
				4'd0:    stage_tag_q[7:0]      <= byte_s1;
				4'd1:    stage_tag_q[15:8]     <= byte_s1;
				4'd2:    stage_ch_q[7:0]       <= byte_s1;
				4'd3:    stage_ch_q[15:8]      <= byte_s1;
				4'd4:    stage_rate_q[7:0]     <= byte_s1;
				4'd5:    stage_rate_q[15:8]    <= byte_s1;
				4'd6:    stage_rate_q[23:16]   <= byte_s1;
				4'd7:    stage_rate_q[31:24]   <= byte_s1;
				4'd12:   stage_align_q[7:0]    <= byte_s1;
				4'd13:   stage_align_q[15:8]   <= byte_s1;
				4'd14:   stage_bits_lo_q       <= byte_s1;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		info.phase       = phase_q;
		info.cut_header  = byte_count_q != 4'd0;
		info.error_code  = error_q;
		info.format_ok   = format_ok_q;
		info.data_seen   = data_seen_q;
		info.channels    = channels_q;
		info.bits        = bits_q;
		info.align       = align_q;
		info.rate        = rate_q;
		info.data_length = data_length_q;
	end

	rwp_verdict u_verdict (
		.info    (info),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q          <= mode_s1;
			audio_byte_q    <= mode_s1 ? 8'd0 : byte_s1;
			status_q        <= mode_s1 ? verdict.status : ST_OK;
			channel_count_q <= mode_s1 ? channels_q : 16'd0;
			sample_bits_q   <= mode_s1 ? bits_q : 16'd0;
			rate_hz_q       <= mode_s1 ? rate_q : 32'd0;
			frame_bytes_q   <= mode_s1 ? align_q : 16'd0;
			payload_size_q  <= mode_s1 ? data_length_q : 31'd0;
			frame_total_q   <= mode_s1 ? verdict.frame_total : 31'd0;
			play_format_q   <= mode_s1 ? verdict.play_format : 2'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign audio_byte    = audio_byte_q;
	assign status        = status_q;
	assign channel_count = channel_count_q;
	assign sample_bits   = sample_bits_q;
	assign rate_hz       = rate_hz_q;
	assign frame_bytes   = frame_bytes_q;
	assign payload_size  = payload_size_q;
	assign frame_total   = frame_total_q;
	assign play_format   = play_format_q;

	// A good verdict always carries a frame size of one, two or four bytes.
	`RWP_ASSERT(a_ok_align, (out_valid && kind && (status == ST_OK)) |-> ((frame_bytes == 16'd1) || (frame_bytes == 16'd2) || (frame_bytes == 16'd4)), "verdict ok with bad frame size")
	`RWP_ASSERT(a_audio_clean, (out_valid && !kind) |-> ((status == ST_OK) && (channel_count == 16'd0) && (frame_total == 31'd0)), "audio transaction carries verdict fields")
	`RWP_ASSERT(a_end_resets, (fire && mode_s1) |=> ((phase_q == PH_HEADER) && !data_seen_q && (error_q == ST_OK)), "parser not cleared after end of stream")
	`RWP_ASSERT(a_data_emits, (fire && !mode_s1 && (phase_q == PH_DATA)) |=> (out_valid && !kind), "data byte not passed out")
	`RWP_ASSERT_NEVER(a_fail_emits, fire && !mode_s1 && (phase_q == PH_FAIL) && emit, "byte emitted after failure")

endmodule
`default_nettype wire
